>>> hw/rtl/hufd_pkg.sv
// Shared types, constants and helpers for the tree-walk Huffman decoder.
`default_nettype none

package hufd_pkg;

  localparam int MAX_LEAVES = 256;
  localparam int NODE_DEPTH = 511;
  localparam int NODE_W     = 9;
  localparam int SYM_W      = 8;
  localparam int BYTE_BITS  = 8;
  localparam int BIT_CNT_W  = 3;

  localparam logic MODE_LOAD   = 1'b0;
  localparam logic MODE_DECODE = 1'b1;

  typedef struct packed {
    logic              mode;
    logic [NODE_W-1:0] node_index;
    logic [NODE_W-1:0] left_child;
    logic [NODE_W-1:0] right_child;
    logic [SYM_W-1:0]  leaf_symbol;
    logic [SYM_W-1:0]  code_byte;
  } in_t;

  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic             last;
  } out_t;

  typedef struct packed {
    logic [NODE_W-1:0] left;
    logic [NODE_W-1:0] right;
  } node_t;

  // One walk event handed from the walker to the emitter.
  typedef struct packed {
    logic             valid;
    logic             hit;
    logic             fin;
    logic [SYM_W-1:0] sym;
  } evt_t;

  function automatic logic [NODE_W-1:0] root_of(input logic [NODE_W-1:0] count);
    logic [NODE_W:0] twice;
    twice = {count, 1'b0} - (NODE_W+1)'(2);
    return twice[NODE_W-1:0];
  endfunction

  function automatic logic [NODE_W-1:0] sat_count(input logic [NODE_W-1:0] value);
    logic [NODE_W-1:0] res;
    res = value;
    if (value == '0) begin
      res = NODE_W'(1);
    end else if (value > NODE_W'(MAX_LEAVES)) begin
      res = NODE_W'(MAX_LEAVES);
    end
    return res;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/hufd_walk.sv
// Node table, symbol table and the tree walker, one bit per cycle unless its event waits to be taken.
`default_nettype none

module hufd_walk (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          dec_start,
  input  wire logic [hufd_pkg::SYM_W-1:0]    code_byte,
  input  wire logic                          load_we,
  input  wire logic [hufd_pkg::NODE_W-1:0]   node_index,
  input  wire logic [hufd_pkg::NODE_W-1:0]   left_child,
  input  wire logic [hufd_pkg::NODE_W-1:0]   right_child,
  input  wire logic [hufd_pkg::SYM_W-1:0]    leaf_symbol,
  input  wire logic [hufd_pkg::NODE_W-1:0]   leaf_count,
  input  wire logic [hufd_pkg::NODE_W-1:0]   root,
  input  wire logic                          cfg_we,
  input  wire logic [hufd_pkg::NODE_W-1:0]   cfg_root,
  input  wire logic                          take,
  output logic                               busy,
  output logic                               fresh,
  output hufd_pkg::evt_t                     evt
);

  hufd_pkg::node_t node_mem [hufd_pkg::NODE_DEPTH];
  logic [hufd_pkg::SYM_W-1:0] sym_mem [hufd_pkg::MAX_LEAVES];

  hufd_pkg::node_t                   node_q;
  logic [hufd_pkg::SYM_W-1:0]        sym_q;
  logic [hufd_pkg::NODE_W-1:0]       ptr;
  logic [hufd_pkg::NODE_W-1:0]       ptr_next;
  logic [hufd_pkg::BYTE_BITS-1:0]    shreg;
  logic [hufd_pkg::BIT_CNT_W-1:0]    cnt;
  logic                              ev_valid;
  logic                              ev_hit;
  logic                              ev_fin;
  logic [hufd_pkg::NODE_W-1:0]       child;
  logic                              hit;
  logic                              last_bit;
  logic                              step;

  always_comb begin
    child = '0;
    if (ptr < hufd_pkg::NODE_W'(hufd_pkg::NODE_DEPTH)) begin
      child = shreg[hufd_pkg::BYTE_BITS-1] ? node_q.right : node_q.left;
    end
    hit      = child < leaf_count;
    last_bit = cnt == hufd_pkg::BIT_CNT_W'(hufd_pkg::BYTE_BITS - 1);
    step     = busy && (!ev_valid || take);
    if (cfg_we) begin
      ptr_next = cfg_root;
    end else if (step) begin
      ptr_next = hit ? root : child;
    end else begin
      ptr_next = ptr;
    end
  end

  // Node table: read every cycle at the next pointer.
  always_ff @(posedge clk) begin
    if (load_we && (node_index < hufd_pkg::NODE_W'(hufd_pkg::NODE_DEPTH))) begin
      node_mem[node_index] <= '{left: left_child, right: right_child};
    end
    node_q <= node_mem[ptr_next];
  end

  always_ff @(posedge clk) begin
    if (load_we && (node_index < hufd_pkg::NODE_W'(hufd_pkg::MAX_LEAVES))) begin
      sym_mem[node_index[hufd_pkg::SYM_W-1:0]] <= leaf_symbol;
    end
    if (step) begin
      sym_q <= sym_mem[child[hufd_pkg::SYM_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr      <= hufd_pkg::root_of(hufd_pkg::NODE_W'(hufd_pkg::MAX_LEAVES));
      busy     <= 1'b0;
      fresh    <= 1'b0;
      ev_valid <= 1'b0;
      cnt      <= '0;
    end else begin
      ptr   <= ptr_next;
      // Read data is stale in the cycle after a table write or pointer reload.
      fresh <= !load_we && !cfg_we;
      if (dec_start) begin
        busy  <= 1'b1;
        cnt   <= '0;
        shreg <= code_byte;
      end else if (step) begin
        shreg <= {shreg[hufd_pkg::BYTE_BITS-2:0], 1'b0};
        cnt   <= cnt + hufd_pkg::BIT_CNT_W'(1);
        if (last_bit) begin
          busy <= 1'b0;
        end
      end
      if (step) begin
        ev_valid <= hit || last_bit;
        ev_hit   <= hit;
        ev_fin   <= last_bit;
      end else if (take) begin
        ev_valid <= 1'b0;
      end
    end
  end

  assign evt = '{valid: ev_valid, hit: ev_hit, fin: ev_fin, sym: sym_q};

endmodule

`default_nettype wire

>>> hw/rtl/hufd_emit.sv
// Holds the newest symbol until its last flag is known, then drives the output register.
`default_nettype none

module hufd_emit (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire hufd_pkg::evt_t   evt,
  input  wire logic             out_stall,
  output logic                  take,
  output logic                  out_valid,
  output hufd_pkg::out_t        out_data
);

  logic                        r_valid;
  logic                        r_valid_next;
  logic                        r_final;
  logic                        r_final_next;
  logic [hufd_pkg::SYM_W-1:0]  r_sym;
  logic [hufd_pkg::SYM_W-1:0]  r_sym_next;
  logic                        push;
  logic                        push_last;
  logic                        o_free;

  always_comb begin
    o_free       = !out_valid || !out_stall;
    take         = 1'b0;
    push         = 1'b0;
    push_last    = 1'b0;
    r_valid_next = r_valid;
    r_final_next = r_final;
    r_sym_next   = r_sym;
    if (r_valid && r_final) begin
      // Close out the previous byte first.
      if (o_free) begin
        push         = 1'b1;
        push_last    = 1'b1;
        r_valid_next = 1'b0;
      end
    end else if (evt.valid && (!r_valid || o_free)) begin
      take      = 1'b1;
      push      = r_valid;
      push_last = !evt.hit;
      if (evt.hit) begin
        r_valid_next = 1'b1;
        r_final_next = evt.fin;
        r_sym_next   = evt.sym;
      end else begin
        r_valid_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      r_valid   <= 1'b0;
      r_final   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      r_valid <= r_valid_next;
      r_final <= r_final_next;
      if (push) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    r_sym <= r_sym_next;
    if (push) begin
      out_data <= '{symbol: r_sym, last: push_last};
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/huffman_tree_walk_decoder_core.sv
// A load beat is written at its accept edge; the next beat waits until the read is fresh.
// A decode beat walks its code byte one bit per cycle while the emitter takes each event.
// The node table read feeding the next bit sets that rate; a symbol is held until the event
// that closes it (next hit or last bit) is taken; one that ends a byte is pushed on its own.
// Reset (synchronous, rst high): leaf count 256, pointer at root 510, no result pending;
// node and symbol tables hold whatever was last loaded.
`default_nettype none

module huffman_tree_walk_decoder_core (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire hufd_pkg::in_t                in_data,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output hufd_pkg::out_t                    out_data,
  input  wire logic                         cfg_we,
  input  wire logic [hufd_pkg::NODE_W-1:0]  cfg_data
);

  logic [hufd_pkg::NODE_W-1:0] leaf_count;
  logic [hufd_pkg::NODE_W-1:0] cfg_count;
  logic                        in_accept;
  logic                        dec_start;
  logic                        load_we;
  logic                        walk_busy;
  logic                        walk_fresh;
  logic                        take;
  hufd_pkg::evt_t              evt;

  // Take a beat only when the walker is idle and its table read is current.
  assign in_stall  = walk_busy || !walk_fresh;
  assign in_accept = in_valid && !in_stall;
  assign dec_start = in_accept && (in_data.mode == hufd_pkg::MODE_DECODE);
  assign load_we   = in_accept && (in_data.mode == hufd_pkg::MODE_LOAD);
  assign cfg_count = hufd_pkg::sat_count(cfg_data);

  // Leaf count register: saturate into 1..MAX_LEAVES.
  always_ff @(posedge clk) begin
    if (rst) begin
      leaf_count <= hufd_pkg::NODE_W'(hufd_pkg::MAX_LEAVES);
    end else if (cfg_we) begin
      leaf_count <= cfg_count;
    end
  end

  // Walker: shifts the code byte out MSB first, one node step per cycle unless its event waits.
  hufd_walk u_walk (
    .clk         (clk),
    .rst         (rst),
    .dec_start   (dec_start),
    .code_byte   (in_data.code_byte),
    .load_we     (load_we),
    .node_index  (in_data.node_index),
    .left_child  (in_data.left_child),
    .right_child (in_data.right_child),
    .leaf_symbol (in_data.leaf_symbol),
    .leaf_count  (leaf_count),
    .root        (hufd_pkg::root_of(leaf_count)),
    .cfg_we      (cfg_we),
    .cfg_root    (hufd_pkg::root_of(cfg_count)),
    .take        (take),
    .busy        (walk_busy),
    .fresh       (walk_fresh),
    .evt         (evt)
  );

  // Emitter: one symbol held back so the final one of a byte gets its last flag.
  hufd_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .evt       (evt),
    .out_stall (out_stall),
    .take      (take),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

`ifndef ASSERT_OFF
  a_decode_starts_walk : assert property (@(posedge clk) disable iff (rst)
    dec_start |=> walk_busy)
    else $error("decode beat did not start the walk");

  a_load_marks_stale : assert property (@(posedge clk) disable iff (rst)
    load_we |=> !walk_fresh)
    else $error("table read not marked stale after load");

  a_take_needs_event : assert property (@(posedge clk) disable iff (rst)
    take |-> evt.valid)
    else $error("emitter took an empty event");
`endif

endmodule

`default_nettype wire

>>> bench/huffman_tree_walk_decoder_core_test.sv
// Self-checking bench for the tree-walk Huffman decoder: directed trees, then random trees.
`default_nettype none

module huffman_tree_walk_decoder_core_test;

  typedef logic [hufd_pkg::NODE_W-1:0] node_ref_t;
  typedef logic [hufd_pkg::SYM_W-1:0]  sym_ref_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  hufd_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  hufd_pkg::out_t out_data;
  logic cfg_we = 1'b0;
  node_ref_t cfg_data = '0;

  huffman_tree_walk_decoder_core dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  // Shadow of the decoder: node tables, leaf count and walk position.
  node_ref_t left_of[hufd_pkg::NODE_DEPTH];
  node_ref_t right_of[hufd_pkg::NODE_DEPTH];
  sym_ref_t sym_of[hufd_pkg::MAX_LEAVES];
  node_ref_t leaves = node_ref_t'(hufd_pkg::MAX_LEAVES);
  node_ref_t cursor = node_ref_t'(2 * hufd_pkg::MAX_LEAVES - 2);

  // Symbols the decoder still owes, oldest first.
  hufd_pkg::out_t expected_symbols[$];
  // Leaf entries of the current tree; safe targets for stray reloads.
  node_ref_t live_leaves[$];

  bit failed = 1'b0;
  // Set to run a stretch with no gaps on either side.
  bit steady = 1'b0;
  int stall_left = 0;

  function automatic node_ref_t root_index(input node_ref_t count);
    return node_ref_t'(2 * count - 2);
  endfunction

  function automatic node_ref_t clamp_leaves(input node_ref_t value);
    if (value == '0) begin
      return node_ref_t'(1);
    end
    if (value > hufd_pkg::MAX_LEAVES) begin
      return node_ref_t'(hufd_pkg::MAX_LEAVES);
    end
    return value;
  endfunction

  function automatic node_ref_t rnd_node();
    return node_ref_t'($urandom_range(0, 511));
  endfunction

  function automatic sym_ref_t rnd_byte();
    return sym_ref_t'($urandom_range(0, 255));
  endfunction

  // Load beat; the code byte is don't-care, so fill it with noise.
  function automatic hufd_pkg::in_t load_beat(input node_ref_t idx, input node_ref_t lc,
                                              input node_ref_t rc, input sym_ref_t sym);
    hufd_pkg::in_t beat;
    beat.mode        = hufd_pkg::MODE_LOAD;
    beat.node_index  = idx;
    beat.left_child  = lc;
    beat.right_child = rc;
    beat.leaf_symbol = sym;
    beat.code_byte   = rnd_byte();
    return beat;
  endfunction

  // Decode beat; the table fields are don't-care, so fill them with noise.
  function automatic hufd_pkg::in_t decode_beat(input sym_ref_t code);
    hufd_pkg::in_t beat;
    beat.mode        = hufd_pkg::MODE_DECODE;
    beat.node_index  = rnd_node();
    beat.left_child  = rnd_node();
    beat.right_child = rnd_node();
    beat.leaf_symbol = rnd_byte();
    beat.code_byte   = code;
    return beat;
  endfunction

  // Apply one accepted beat to the shadow state and queue the symbols it yields.
  task automatic walk_tree(input hufd_pkg::in_t beat);
    sym_ref_t bits;
    node_ref_t step;
    int made;
    hufd_pkg::out_t hit;
    if (beat.mode == hufd_pkg::MODE_LOAD) begin
      // Out-of-range indexes drop; only leaf-range indexes carry a symbol.
      if (beat.node_index < hufd_pkg::NODE_DEPTH) begin
        left_of[beat.node_index]  = beat.left_child;
        right_of[beat.node_index] = beat.right_child;
        if (beat.node_index < hufd_pkg::MAX_LEAVES) begin
          sym_of[beat.node_index[hufd_pkg::SYM_W-1:0]] = beat.leaf_symbol;
        end
      end
    end else begin
      bits = beat.code_byte;
      made = 0;
      repeat (hufd_pkg::BYTE_BITS) begin
        // A pointer past the table reads as child zero.
        step = '0;
        if (cursor < hufd_pkg::NODE_DEPTH) begin
          step = bits[hufd_pkg::SYM_W-1] ? right_of[cursor] : left_of[cursor];
        end
        cursor = step;
        if (cursor < leaves) begin
          hit.symbol = sym_of[cursor[hufd_pkg::SYM_W-1:0]];
          hit.last   = 1'b0;
          expected_symbols.push_back(hit);
          made++;
          cursor = root_index(leaves);
        end
        bits = bits << 1;
      end
      // Flag the final symbol of this byte.
      if (made != 0) begin
        hit = expected_symbols.pop_back();
        hit.last = 1'b1;
        expected_symbols.push_back(hit);
      end
    end
  endtask

  // Present one beat after a random gap, none when steady, and hold it until taken.
  task automatic send_item(input hufd_pkg::in_t beat);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk); while (in_stall);
    walk_tree(beat);
  endtask

  // Drop valid, drain every owed symbol, then let a trailing walk finish.
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_symbols.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Write the leaf count while idle; the walk restarts at the new root.
  task automatic set_leaves(input node_ref_t value);
    settle();
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    leaves = clamp_leaves(value);
    cursor = root_index(leaves);
  endtask

  // Leaf reference for a random tree: a leaf index, now and then the off-table node.
  function automatic node_ref_t leaf_ref();
    if ($urandom_range(0, 11) == 0) begin
      return node_ref_t'(511);
    end
    if (leaves == 1) begin
      return '0;
    end
    return node_ref_t'($urandom_range(0, leaves - 1));
  endfunction

  // Build and load a random tree under the current root. Every node the walk
  // can reach gets loaded, so no read ever lands on an unwritten entry.
  // With chain set the tree degenerates into a single deep spine.
  task automatic plant_tree(input int inner, input bit chain);
    node_ref_t nodes[$];
    node_ref_t pool[$];
    node_ref_t lc[32];
    node_ref_t rc[32];
    bit taken[hufd_pkg::NODE_DEPTH];
    bit loaded[hufd_pkg::MAX_LEAVES];
    node_ref_t pick;
    node_ref_t first;
    node_ref_t second;
    node_ref_t child;
    int slot;
    nodes.push_back(root_index(leaves));
    taken[nodes[0]] = 1'b1;
    while (nodes.size() < inner) begin
      pick = node_ref_t'($urandom_range(leaves, hufd_pkg::NODE_DEPTH - 1));
      if (!taken[pick]) begin
        taken[pick] = 1'b1;
        nodes.push_back(pick);
      end
    end
    // Merge subtrees bottom up; the last merge yields the root.
    repeat (inner + 1) pool.push_back(leaf_ref());
    for (int k = inner - 1; k >= 0; k--) begin
      slot = chain ? pool.size() - 1 : $urandom_range(0, pool.size() - 1);
      first = pool[slot];
      pool.delete(slot);
      slot = $urandom_range(0, pool.size() - 1);
      second = pool[slot];
      pool.delete(slot);
      if ($urandom_range(0, 1) != 0) begin
        lc[k] = first;
        rc[k] = second;
      end else begin
        lc[k] = second;
        rc[k] = first;
      end
      pool.push_back(nodes[k]);
    end
    live_leaves.delete();
    // With one leaf node zero is the root and gets its symbol from the root load.
    if (leaves > 1) begin
      // Keep leaf zero loaded: the off-table node falls through to it.
      live_leaves.push_back('0);
      loaded[0] = 1'b1;
      for (int j = 0; j < 2 * inner; j++) begin
        child = (j % 2 != 0) ? rc[j / 2] : lc[j / 2];
        if (child < leaves && !loaded[child[hufd_pkg::SYM_W-1:0]]) begin
          loaded[child[hufd_pkg::SYM_W-1:0]] = 1'b1;
          live_leaves.push_back(child);
        end
      end
      foreach (live_leaves[j]) begin
        send_item(load_beat(live_leaves[j], rnd_node(), rnd_node(), rnd_byte()));
      end
    end
    for (int k = 0; k < inner; k++) begin
      send_item(load_beat(nodes[k], lc[k], rc[k], rnd_byte()));
    end
  endtask

  // Reset leaf count of 256: root at 510 with two leaves at the index extremes.
  task automatic test_reset_tree();
    send_item(load_beat(9'd0, rnd_node(), rnd_node(), 8'h00));
    send_item(load_beat(9'd255, 9'h1FF, 9'h000, 8'hFF));
    send_item(load_beat(9'd510, 9'd0, 9'd255, 8'h5A));
    send_item(decode_beat(8'h00));
    send_item(decode_beat(8'hFF));
    send_item(decode_beat(8'hA5));
  endtask

  // Ignored load at the top index, an inner node above the symbol range, and a
  // child past the table that drops the walk onto node zero.
  task automatic test_out_of_range_walk();
    send_item(load_beat(9'h1FF, 9'h1FF, 9'h1FF, 8'hFF));
    send_item(load_beat(9'd300, 9'd0, 9'd255, 8'hAA));
    send_item(load_beat(9'd510, 9'd300, 9'h1FF, 8'h00));
    send_item(decode_beat(8'h80));
  endtask

  // Spine deeper than one byte: the first byte yields nothing, the next resumes.
  task automatic test_byte_without_symbol();
    set_leaves(9'd2);
    send_item(load_beat(9'd0, rnd_node(), rnd_node(), 8'h11));
    send_item(load_beat(9'd1, rnd_node(), rnd_node(), 8'hEE));
    for (int k = 2; k < 10; k++) begin
      send_item(load_beat(node_ref_t'(k), node_ref_t'(k + 1), node_ref_t'(k % 2), rnd_byte()));
    end
    send_item(load_beat(9'd10, 9'd0, 9'd1, rnd_byte()));
    send_item(decode_beat(8'h00));
    send_item(decode_beat(8'h00));
    send_item(decode_beat(8'hFF));
  endtask

  // A zero write clamps to one leaf: node zero is both root and leaf.
  task automatic test_single_leaf();
    set_leaves(9'd0);
    send_item(load_beat(9'd0, 9'd0, 9'd7, 8'h3C));
    send_item(load_beat(9'd7, 9'd0, 9'h1FF, rnd_byte()));
    send_item(decode_beat(8'h0F));
    send_item(decode_beat(8'hB6));
  endtask

  // One phase per leaf count, clamped writes and both extremes among them.
  task automatic test_random_trees();
    node_ref_t counts[9];
    counts = '{9'd3, 9'd511, 9'd1, 9'd2, 9'd256, 9'd255, 9'd9, 9'd0, 9'd17};
    foreach (counts[p]) begin
      set_leaves(counts[p]);
      steady = (p % 3 == 1);
      plant_tree($urandom_range(1, 10), $urandom_range(0, 3) == 0);
      repeat (30) begin
        if ($urandom_range(0, 6) != 0) begin
          send_item(decode_beat(rnd_byte()));
        end else if (leaves > 1 && $urandom_range(0, 1) != 0) begin
          // Reload a leaf: new symbol, children that are never followed.
          send_item(load_beat(live_leaves[$urandom_range(0, live_leaves.size() - 1)],
                              rnd_node(), rnd_node(), rnd_byte()));
        end else begin
          send_item(load_beat(9'h1FF, rnd_node(), rnd_node(), rnd_byte()));
        end
      end
    end
    steady = 1'b0;
  endtask

  // Take each symbol beat, compare it with the oldest owed one, then draw the
  // stall for the next beat. Stall cycles count down only against a valid beat.
  always @(posedge clk) begin
    hufd_pkg::out_t want;
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_symbols.size() == 0) begin
          $error("symbol: expected none, got %0d", out_data.symbol);
          failed = 1'b1;
        end else begin
          want = expected_symbols.pop_front();
          if (out_data.symbol !== want.symbol) begin
            $error("symbol: expected %0d, got %0d", want.symbol, out_data.symbol);
            failed = 1'b1;
          end
          if (out_data.last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, out_data.last);
            failed = 1'b1;
          end
        end
        stall_left = steady ? 0 : $urandom_range(0, 3);
      end else if (out_valid && stall_left != 0) begin
        stall_left--;
      end
      out_stall <= (stall_left != 0);
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_tree();
    test_out_of_range_walk();
    test_byte_without_symbol();
    test_single_leaf();
    test_random_trees();
    settle();
    if (!failed && expected_symbols.size() == 0) begin
      $display("huffman_tree_walk_decoder_core: match");
    end else begin
      $display("huffman_tree_walk_decoder_core: mismatch");
    end
    $finish;
  end

  // Hard stop if the decoder wedges.
  initial begin
    #20_000_000;
    $display("huffman_tree_walk_decoder_core: mismatch");
    $finish;
  end

endmodule

`default_nettype wire
